@@ src/ewsm_pkg.sv @@
package ewsm_pkg;

  // Input command codes
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Reported direction codes
  localparam logic [1:0] DIR_STOPPED = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_WINDOW_TICKS = 2'd0;
  localparam logic [1:0] REG_RPM_SCALE    = 2'd1;
  localparam logic [1:0] REG_MAX_RPM      = 2'd2;

  // Register and field widths
  localparam int TICK_BITS    = 16;
  localparam int SCALE_BITS   = 32;
  localparam int MAX_RPM_BITS = 14;
  localparam int RPM_BITS     = 22;
  localparam int SPEED_BITS   = 17;
  localparam int TOTAL_BITS   = 32;
  localparam int CFG_BITS     = 32;

  // Accepted window rpm in Q.16 never exceeds the glitch limit, which fits 30 bits
  localparam int RATE_BITS = 30;
  localparam logic [RATE_BITS-1:0] GLITCH_RPM_Q16 = 30'd983040000;

  // Quotient bits below the clamp at 1.0
  localparam int QUOT_BITS = 16;
  localparam logic [SPEED_BITS-1:0] SPEED_ONE = 17'h10000;

  // Fraction bits dropped from Q.16 to Q.8
  localparam int RPM_SHIFT = 8;

  // Reset values of the configuration registers
  localparam logic [TICK_BITS-1:0]    WINDOW_TICKS_RESET = 16'd10;
  localparam logic [SCALE_BITS-1:0]   RPM_SCALE_RESET    = 32'd65536;
  localparam logic [MAX_RPM_BITS-1:0] MAX_RPM_RESET      = 14'd1000;

endpackage

@@ src/ewsm_ser_mul.sv @@
// Shift-add multiplier: one multiplier bit per cycle, LSB first.
module ewsm_ser_mul #(
  parameter int AW = 16,
  parameter int BW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic            busy,
  output logic [AW+BW-1:0] product
);

  localparam int CW = $clog2(AW + 1);

  logic [BW-1:0] hi;
  logic [AW-1:0] lo;
  logic [BW-1:0] mcand;
  logic [CW-1:0] cnt;
  logic [BW:0]   sum;

  // Add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : {(BW+1){1'b0}});
  assign product = {hi, lo};

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(AW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift the partial product right by one bit each step
  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= a;
      mcand <= b;
    end else if (busy) begin
      {hi, lo} <= {sum, lo[AW-1:1]};
    end
  end

endmodule

@@ src/ewsm_ser_div.sv @@
// Restoring divider: one quotient bit per cycle, MSB first.
// The caller guarantees the quotient fits QUOT_BITS.
module ewsm_ser_div
  import ewsm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [RATE_BITS-1:0]    dividend,
  input  logic [MAX_RPM_BITS-1:0] divisor,
  output logic                    busy,
  output logic [QUOT_BITS-1:0]    quotient
);

  localparam int CW = $clog2(QUOT_BITS + 1);
  localparam int PAD = RATE_BITS - MAX_RPM_BITS - (QUOT_BITS - 1);

  logic [RATE_BITS-1:0] rem;
  logic [RATE_BITS-1:0] dsh;
  logic [CW-1:0]        cnt;
  logic                 ge;

  assign ge = (rem >= dsh);

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(QUOT_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Subtract the aligned divisor where it fits, then shift it down
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= {{PAD{1'b0}}, divisor, {(QUOT_BITS-1){1'b0}}};
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh      <= dsh >> 1;
      quotient <= {quotient[QUOT_BITS-2:0], ge};
    end
  end

endmodule

@@ src/encoder_window_speed_meter.sv @@
// Encoder window speed meter for one motor channel. Each input item is an
// A-phase edge (command 0, carrying the B level: high means forward) or an
// update tick (command 1), and each item yields one result item. Edges and
// ticks that do not close a window post their result straight from idle. A
// tick that closes the window runs a bit-serial multiply of count by
// rpm_scale and, alongside it, the reject fallback multiply of the 17-bit
// held speed; once both are done, a serial division by max_rpm yields the 16
// quotient bits below the 1.0 clamp. A rejected window, a zero max_rpm or a
// clamped speed skips the division. Results sit in an output register; a new
// item is taken once the block is idle and that register is free or being
// drained. Write configuration only while the block is idle.
module encoder_window_speed_meter
  import ewsm_pkg::*;
#(
  parameter int PULSE_COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    command,
  input  logic                    phase_b_level,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    window_done,
  output logic                    glitch_rejected,
  output logic [RPM_BITS-1:0]     rpm_q8,
  output logic [SPEED_BITS-1:0]   speed_q16,
  output logic [1:0]              direction,
  output logic [TOTAL_BITS-1:0]   total_pulses,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  localparam int PW = PULSE_COUNT_BITS + SCALE_BITS;
  localparam int SPW = SPEED_BITS + MAX_RPM_BITS;
  localparam logic [PW-1:0] GLITCH_LIMIT = PW'(GLITCH_RPM_Q16);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0] state;

  logic [TICK_BITS-1:0]    window_ticks;
  logic [SCALE_BITS-1:0]   rpm_scale;
  logic [MAX_RPM_BITS-1:0] max_rpm;

  logic [PULSE_COUNT_BITS-1:0] window_pulses;
  logic [TOTAL_BITS-1:0]       pulse_total;
  logic [1:0]                  edge_direction;
  logic [1:0]                  reported_direction;
  logic [SPEED_BITS-1:0]       speed_value;
  logic [RPM_BITS-1:0]         rpm_value;
  logic [TICK_BITS-1:0]        tick_count;

  logic                 in_fire;
  logic [TICK_BITS:0]   tick_next;
  logic                 closes;
  logic                 mul_start;
  logic                 rate_busy;
  logic                 rej_busy;
  logic                 div_busy;
  logic                 div_start;
  logic [PW-1:0]        rate_prod;
  logic [SPW-1:0]       rej_prod;
  logic [QUOT_BITS-1:0] quot;
  logic [RATE_BITS-1:0] rate_q16;
  logic                 glitch;
  logic                 clamp;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign tick_next = {1'b0, tick_count} + 1'b1;
  assign closes    = (command == CMD_TICK) && (tick_next >= {1'b0, window_ticks});
  assign mul_start = in_fire && closes;

  assign rate_q16 = rate_prod[RATE_BITS-1:0];
  assign glitch   = (rate_prod > GLITCH_LIMIT);
  assign clamp    = (rate_q16 >= {max_rpm, {QUOT_BITS{1'b0}}});
  assign div_start = (state == S_MUL) && !rate_busy && !rej_busy && !glitch
                     && (max_rpm != '0) && !clamp;

  assign rpm_q8       = rpm_value;
  assign speed_q16    = speed_value;
  assign direction    = reported_direction;
  assign total_pulses = pulse_total;

  // Window rpm in Q.16: count times rpm per pulse
  ewsm_ser_mul #(
    .AW(PULSE_COUNT_BITS),
    .BW(SCALE_BITS)
  ) u_rate_mul (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .a(window_pulses),
    .b(rpm_scale),
    .busy(rate_busy),
    .product(rate_prod)
  );

  // Fallback rpm for a rejected window: kept speed times full scale
  ewsm_ser_mul #(
    .AW(SPEED_BITS),
    .BW(MAX_RPM_BITS)
  ) u_rej_mul (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .a(speed_value),
    .b(max_rpm),
    .busy(rej_busy),
    .product(rej_prod)
  );

  // Normalize the window rpm to full scale
  ewsm_ser_div u_speed_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(rate_q16),
    .divisor(max_rpm),
    .busy(div_busy),
    .quotient(quot)
  );

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_TICKS_RESET;
      rpm_scale    <= RPM_SCALE_RESET;
      max_rpm      <= MAX_RPM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_TICKS: window_ticks <= cfg_data[TICK_BITS-1:0];
        REG_RPM_SCALE:    rpm_scale    <= cfg_data[SCALE_BITS-1:0];
        REG_MAX_RPM:      max_rpm      <= cfg_data[MAX_RPM_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // Count edges and ticks, close windows, and post results
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      window_done        <= 1'b0;
      glitch_rejected    <= 1'b0;
      window_pulses      <= '0;
      pulse_total        <= '0;
      edge_direction     <= DIR_STOPPED;
      reported_direction <= DIR_STOPPED;
      speed_value        <= '0;
      rpm_value          <= '0;
      tick_count         <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            window_done     <= 1'b0;
            glitch_rejected <= 1'b0;
            if (command == CMD_EDGE) begin
              if (window_pulses != {PULSE_COUNT_BITS{1'b1}}) begin
                window_pulses <= window_pulses + 1'b1;
              end
              pulse_total    <= pulse_total + 1'b1;
              edge_direction <= phase_b_level ? DIR_FORWARD : DIR_REVERSE;
              out_valid      <= 1'b1;
            end else if (!closes) begin
              tick_count <= tick_next[TICK_BITS-1:0];
              out_valid  <= 1'b1;
            end else begin
              tick_count    <= '0;
              window_pulses <= '0;
              state         <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (!rate_busy && !rej_busy) begin
            if (glitch) begin
              // Reject: keep speed and direction, rebuild rpm
              rpm_value       <= rej_prod[RPM_SHIFT +: RPM_BITS];
              glitch_rejected <= 1'b1;
              window_done     <= 1'b1;
              out_valid       <= 1'b1;
              state           <= S_IDLE;
            end else begin
              rpm_value          <= rate_q16[RPM_SHIFT +: RPM_BITS];
              reported_direction <= edge_direction;
              if (max_rpm == '0) begin
                speed_value <= (rate_q16 != '0) ? SPEED_ONE : '0;
                window_done <= 1'b1;
                out_valid   <= 1'b1;
                state       <= S_IDLE;
              end else if (clamp) begin
                speed_value <= SPEED_ONE;
                window_done <= 1'b1;
                out_valid   <= 1'b1;
                state       <= S_IDLE;
              end else begin
                state <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            speed_value <= {1'b0, quot};
            window_done <= 1'b1;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ verif/testbench.sv @@
module testbench
  import ewsm_pkg::*;
;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    logic                  done;
    logic                  rejected;
    logic [RPM_BITS-1:0]   rpm;
    logic [SPEED_BITS-1:0] speed;
    logic [1:0]            dir;
    logic [TOTAL_BITS-1:0] total;
  } meter_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  command = CMD_EDGE;
  logic                  phase_b_level = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  window_done;
  logic                  glitch_rejected;
  logic [RPM_BITS-1:0]   rpm_q8;
  logic [SPEED_BITS-1:0] speed_q16;
  logic [1:0]            direction;
  logic [TOTAL_BITS-1:0] total_pulses;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = REG_WINDOW_TICKS;
  logic [CFG_BITS-1:0]   cfg_data = '0;

  // Shadow copy of the meter: configuration and state
  logic [TICK_BITS-1:0]    cfg_window;
  logic [SCALE_BITS-1:0]   cfg_scale;
  logic [MAX_RPM_BITS-1:0] cfg_full_rpm;
  logic [15:0]             pulses_in_window;
  logic [TOTAL_BITS-1:0]   pulse_count;
  logic [1:0]              latched_dir;
  logic [1:0]              shown_dir;
  logic [SPEED_BITS-1:0]   speed_now;
  logic [RPM_BITS-1:0]     rpm_now;
  logic [TICK_BITS-1:0]    ticks_seen;

  meter_result_t pending_results[$];
  int            errors = 0;
  int            cycles = 0;
  bit            calm = 1'b0;
  int            ready_hold = 0;

  encoder_window_speed_meter dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .phase_b_level   (phase_b_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .window_done     (window_done),
    .glitch_rejected (glitch_rejected),
    .rpm_q8          (rpm_q8),
    .speed_q16       (speed_q16),
    .direction       (direction),
    .total_pulses    (total_pulses),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Reset the shadow meter
  function automatic void reset_meter();
    cfg_window       = WINDOW_TICKS_RESET;
    cfg_scale        = RPM_SCALE_RESET;
    cfg_full_rpm     = MAX_RPM_RESET;
    pulses_in_window = '0;
    pulse_count      = '0;
    latched_dir      = DIR_STOPPED;
    shown_dir        = DIR_STOPPED;
    speed_now        = '0;
    rpm_now          = '0;
    ticks_seen       = '0;
  endfunction

  // Advance the shadow meter by one item and return the result it shows
  function automatic meter_result_t advance_meter(logic cmd, logic b_level);
    meter_result_t r;
    logic [16:0]   next_tick;
    logic [63:0]   window_rpm;
    logic [63:0]   rebuilt;
    logic [63:0]   quotient;
    r.done     = 1'b0;
    r.rejected = 1'b0;
    if (cmd == CMD_EDGE) begin
      if (pulses_in_window != 16'hFFFF) pulses_in_window = pulses_in_window + 1'b1;
      pulse_count = pulse_count + 1'b1;
      latched_dir = b_level ? DIR_FORWARD : DIR_REVERSE;
    end else begin
      next_tick = {1'b0, ticks_seen} + 17'd1;
      if (next_tick < {1'b0, cfg_window}) begin
        ticks_seen = next_tick[15:0];
      end else begin
        ticks_seen = '0;
        r.done     = 1'b1;
        window_rpm = 64'(pulses_in_window) * 64'(cfg_scale);
        pulses_in_window = '0;
        if (window_rpm > 64'(GLITCH_RPM_Q16)) begin
          // Keep speed and direction, rebuild rpm from the held speed
          r.rejected = 1'b1;
          rebuilt = (64'(speed_now) * 64'(cfg_full_rpm)) >> RPM_SHIFT;
          rpm_now = rebuilt[RPM_BITS-1:0];
        end else begin
          rebuilt = window_rpm >> RPM_SHIFT;
          rpm_now = rebuilt[RPM_BITS-1:0];
          if (cfg_full_rpm == '0) begin
            speed_now = (window_rpm != 0) ? SPEED_ONE : '0;
          end else begin
            quotient  = window_rpm / 64'(cfg_full_rpm);
            speed_now = (quotient > 64'(SPEED_ONE)) ? SPEED_ONE : quotient[SPEED_BITS-1:0];
          end
          shown_dir = latched_dir;
        end
      end
    end
    r.rpm   = rpm_now;
    r.speed = speed_now;
    r.dir   = shown_dir;
    r.total = pulse_count;
    return r;
  endfunction

  // Drive the result side: stall at random unless in a calm stretch
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_hold != 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold <= idle_cycles();
    end
  end

  // Compare each result item with the oldest prediction
  always @(posedge clk) begin
    meter_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no item waiting for it");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (window_done !== want.done) begin
          $error("window_done: expected %0d, got %0d", want.done, window_done);
          errors++;
        end
        if (glitch_rejected !== want.rejected) begin
          $error("glitch_rejected: expected %0d, got %0d", want.rejected, glitch_rejected);
          errors++;
        end
        if (rpm_q8 !== want.rpm) begin
          $error("rpm_q8: expected %0d, got %0d", want.rpm, rpm_q8);
          errors++;
        end
        if (speed_q16 !== want.speed) begin
          $error("speed_q16: expected %0d, got %0d", want.speed, speed_q16);
          errors++;
        end
        if (direction !== want.dir) begin
          $error("direction: expected %0d, got %0d", want.dir, direction);
          errors++;
        end
        if (total_pulses !== want.total) begin
          $error("total_pulses: expected %0d, got %0d", want.total, total_pulses);
          errors++;
        end
      end
    end
  end

  // Send one item and record its prediction once it is taken
  task automatic send_item(input logic cmd, input logic b_level);
    int gap;
    gap = calm ? 0 : idle_cycles();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    phase_b_level <= b_level;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(advance_meter(cmd, b_level));
  endtask

  // Hold off the sender until every predicted result has arrived
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write all three registers; the block must be idle
  task automatic program_meter(input logic [TICK_BITS-1:0] ticks,
                               input logic [SCALE_BITS-1:0] scale,
                               input logic [MAX_RPM_BITS-1:0] full_rpm);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_TICKS;
    cfg_data  <= CFG_BITS'(ticks);
    @(posedge clk);
    cfg_window = ticks;
    cfg_index <= REG_RPM_SCALE;
    cfg_data  <= CFG_BITS'(scale);
    @(posedge clk);
    cfg_scale = scale;
    cfg_index <= REG_MAX_RPM;
    cfg_data  <= CFG_BITS'(full_rpm);
    @(posedge clk);
    cfg_full_rpm = full_rpm;
    cfg_we <= 1'b0;
  endtask

  // Reset registers: idle ticks, then a window closes on the tenth tick
  task automatic test_reset_defaults();
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_EDGE, 1'b0);
    send_item(CMD_EDGE, 1'b1);
    repeat (9) send_item(CMD_TICK, 1'b1);
    wait_for_results();
  endtask

  // Empty window keeps the latched direction; zero window length closes every tick
  task automatic test_short_windows();
    program_meter(16'd1, RPM_SCALE_RESET, MAX_RPM_RESET);
    send_item(CMD_TICK, 1'b0);
    wait_for_results();
    program_meter(16'd0, RPM_SCALE_RESET, MAX_RPM_RESET);
    send_item(CMD_EDGE, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b0);
    wait_for_results();
  endtask

  // Window rpm exactly at the glitch limit, just above it, and far above it
  task automatic test_glitch_limit();
    program_meter(16'd1, SCALE_BITS'(GLITCH_RPM_Q16), 14'd15000);
    send_item(CMD_EDGE, 1'b1);
    send_item(CMD_TICK, 1'b0);
    wait_for_results();
    program_meter(16'd1, SCALE_BITS'(GLITCH_RPM_Q16) + 1'b1, 14'd15000);
    send_item(CMD_EDGE, 1'b0);
    send_item(CMD_TICK, 1'b0);
    wait_for_results();
    program_meter(16'd1, '1, 14'd1);
    send_item(CMD_EDGE, 1'b0);
    send_item(CMD_TICK, 1'b1);
    wait_for_results();
  endtask

  // Zero full-scale rpm, clamp at 1.0 and the smallest nonzero speed
  task automatic test_speed_limits();
    program_meter(16'd1, 32'd1000, '0);
    send_item(CMD_EDGE, 1'b1);
    send_item(CMD_TICK, 1'b0);
    wait_for_results();
    program_meter(16'd1, '1, '0);
    send_item(CMD_EDGE, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b0);
    wait_for_results();
    program_meter(16'd1, 32'd65536 * 32'd2000, 14'd1000);
    send_item(CMD_EDGE, 1'b1);
    send_item(CMD_TICK, 1'b1);
    wait_for_results();
    program_meter(16'd1, 32'd1, 14'd1);
    send_item(CMD_EDGE, 1'b0);
    send_item(CMD_TICK, 1'b0);
    wait_for_results();
  endtask

  // Lower the window length below the running tick count
  task automatic test_window_shrink();
    program_meter(16'hFFFF, RPM_SCALE_RESET, MAX_RPM_RESET);
    repeat (4) send_item(CMD_TICK, 1'b0);
    send_item(CMD_EDGE, 1'b1);
    wait_for_results();
    program_meter(16'd2, RPM_SCALE_RESET, MAX_RPM_RESET);
    send_item(CMD_TICK, 1'b0);
    wait_for_results();
  endtask

  // Run a burst of edges with ticks mixed in, back to back
  task automatic test_back_to_back();
    logic cmd;
    calm = 1'b1;
    program_meter(16'd4, 32'd15000, 14'd15000);
    repeat (150) begin
      cmd = ($urandom_range(0, 9) < 8) ? CMD_EDGE : CMD_TICK;
      send_item(cmd, 1'($urandom_range(0, 1)));
    end
    send_item(CMD_TICK, 1'b0);
    wait_for_results();
    calm = 1'b0;
  endtask

  // Random phases: each picks a setting, then mostly edges with ticks mixed in
  task automatic test_random_traffic();
    int               sent;
    int               count;
    int               edge_pct;
    int               r;
    logic [TICK_BITS-1:0]    ticks;
    logic [SCALE_BITS-1:0]   scale;
    logic [MAX_RPM_BITS-1:0] full_rpm;
    logic             cmd;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0)      ticks = '0;
      else if (r < 7)  ticks = TICK_BITS'($urandom_range(1, 6));
      else if (r == 7) ticks = TICK_BITS'($urandom_range(7, 40));
      else if (r == 8) ticks = '1;
      else             ticks = TICK_BITS'($urandom_range(0, 65535));
      r = $urandom_range(0, 9);
      if (r == 0)      scale = '0;
      else if (r == 1) scale = '1;
      else if (r < 5)  scale = $urandom_range(1, 4_000_000);
      else if (r < 8)  scale = $urandom_range(20_000_000, 400_000_000);
      else             scale = $urandom();
      r = $urandom_range(0, 5);
      if (r == 0)      full_rpm = '0;
      else if (r == 1) full_rpm = 14'd1;
      else if (r == 2) full_rpm = 14'd15000;
      else             full_rpm = MAX_RPM_BITS'($urandom_range(1, 15000));
      calm = ($urandom_range(0, 4) == 0);
      program_meter(ticks, scale, full_rpm);
      count    = $urandom_range(100, 200);
      edge_pct = $urandom_range(40, 95);
      repeat (count) begin
        cmd = ($urandom_range(0, 99) < edge_pct) ? CMD_EDGE : CMD_TICK;
        send_item(cmd, 1'($urandom_range(0, 1)));
        // Pause now and then until the pipeline is empty
        if ($urandom_range(0, 99) == 0) wait_for_results();
      end
      sent += count;
      wait_for_results();
    end
    calm = 1'b0;
  endtask

  initial begin
    reset_meter();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_short_windows();
    test_glitch_limit();
    test_speed_limits();
    test_window_shrink();
    test_back_to_back();
    test_random_traffic();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
